[hw/rtl/fnms_pkg.sv]
// ============================================================================
// fnms_pkg: shared constants and types for the four-neighbour smoothing block
// Widths, register indexes, the per-sample word carried into the gather
// stage and the result group handed to the emitter.
// ============================================================================

package fnms_pkg;

    // Geometry of the line store and of the sample words.
    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int ROW_W       = 16;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CFG_COLS_W  = $clog2(MAX_COLS + 1);
    localparam int CFG_DATA_W  = (ROW_W > CFG_COLS_W) ? ROW_W : CFG_COLS_W;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = CFG_IDX_W'(1);
    localparam int RESET_ROWS = 3;
    localparam int RESET_COLS = 5;

    // Three row banks in one memory.
    localparam int BANKS       = 3;
    localparam int BANK_W      = $clog2(BANKS);
    localparam int STORE_DEPTH = BANKS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Neighbour sums and the reciprocal used for the divide by three.
    localparam int SUM_W        = SAMPLE_W + 2;
    localparam int MAG_W        = SUM_W;
    localparam int RECIP_SHIFT  = SAMPLE_W + 2;
    localparam int RECIP_W      = RECIP_SHIFT - 1;
    localparam int PROD_W       = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

    // Results caused by one sample.
    localparam int GROUP_MAX   = 3;
    localparam int GROUP_IDX_W = $clog2(GROUP_MAX);
    localparam int REM_W       = $clog2(GROUP_MAX + 1);

    typedef enum logic [1:0] {
        DIV_BY_2,
        DIV_BY_3,
        DIV_BY_4
    } divisor_t;

    // One sample with its position and the position flags worked out at acceptance.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       first_row;
        logic                       above_two;
        logic                       last_row;
        logic                       first_col;
        logic                       past_second_col;
        logic                       last_col;
    } item_t;

    // One pending result: neighbour sum, divisor and position.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        divisor_t                divisor;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    eom;
    } result_t;

    // The results caused by one sample; present is always a prefix.
    typedef struct packed {
        logic [GROUP_MAX-1:0]    present;
        result_t [GROUP_MAX-1:0] res;
    } group_t;

endpackage

[hw/rtl/fnms_if.sv]
// ============================================================================
// fnms_if: valid/ready channels of the four-neighbour smoothing block
// The sample channel carries one matrix element per word; the result
// channel carries one smoothed element with its position per word.
// ============================================================================

interface fnms_in_if import fnms_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface fnms_out_if import fnms_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] smoothed_value;
    logic [ROW_W-1:0]           out_row;
    logic [COL_W-1:0]           out_col;
    logic                       last_in_run;
    logic                       end_of_matrix;

    modport source (output valid, output smoothed_value, output out_row, output out_col,
                    output last_in_run, output end_of_matrix, input ready);
    modport sink   (input valid, input smoothed_value, input out_row, input out_col,
                    input last_in_run, input end_of_matrix, output ready);
endinterface

[hw/rtl/four_neighbour_matrix_smoothing.sv]
// A sample's first result passes the gather stage, result queue and output register.
// One sample per cycle unless the output stalls; the output register passes one word
// per cycle, so a bottom-row sample that completes two or three results holds the input
// while they drain. Reset clears the position to row 0, column 0 and the registers to
// 3 rows and 5 columns; the line store is not cleared and is only read where written.
// ============================================================================
// four_neighbour_matrix_smoothing: streaming four-neighbour mean filter
// Samples arrive in raster order; each element's result is the mean of its
// existing up, down, left and right neighbours, emitted with its position.
// ============================================================================

module four_neighbour_matrix_smoothing import fnms_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    fnms_in_if.sink               samples,
    fnms_out_if.source            results
);

    logic [ROW_W-1:0]           cfg_rows_reg;
    logic [ROW_W-1:0]           cfg_rows_next;
    logic [CFG_COLS_W-1:0]      cfg_cols_reg;
    logic [CFG_COLS_W-1:0]      cfg_cols_next;
    logic [ROW_W-1:0]           in_row_reg;
    logic [ROW_W-1:0]           in_row_next;
    logic [COL_W-1:0]           in_col_reg;
    logic [COL_W-1:0]           in_col_next;
    logic [BANK_W-1:0]          bank_reg;
    logic [BANK_W-1:0]          bank_next;
    logic [ROW_W-1:0]           eff_rows;
    logic [CFG_COLS_W-1:0]      eff_cols;
    logic                       last_row;
    logic                       last_col;
    logic [BANK_W-1:0]          bank_up1;
    logic [BANK_W-1:0]          bank_up2;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr_a;
    logic [ADDR_W-1:0]          rd_addr_b;
    logic signed [SAMPLE_W-1:0] rd_data_a;
    logic signed [SAMPLE_W-1:0] rd_data_b;
    logic                       accept;
    logic                       take_ok;
    item_t                      item_in;
    logic                       grp_valid;
    logic                       grp_ready;
    group_t                     grp;

    function automatic logic [BANK_W-1:0] bank_prev(input logic [BANK_W-1:0] bank);
        bank_prev = (bank == '0) ? BANK_W'(BANKS - 1) : bank - BANK_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [BANK_W-1:0] bank,
                                                      input logic [COL_W-1:0] col);
        store_addr = ADDR_W'(bank) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

    assign samples.ready = take_ok;
    assign accept        = samples.valid && take_ok;

    // Matrix size as used, with the register values clamped to the legal range.
    always_comb
    begin
        eff_rows = (cfg_rows_reg < ROW_W'(2)) ? ROW_W'(2) : cfg_rows_reg;
        if (cfg_cols_reg < CFG_COLS_W'(2))
        begin
            eff_cols = CFG_COLS_W'(2);
        end
        else if (cfg_cols_reg > CFG_COLS_W'(MAX_COLS))
        begin
            eff_cols = CFG_COLS_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = cfg_cols_reg;
        end
        last_row = (in_row_reg == eff_rows - ROW_W'(1));
        last_col = (CFG_COLS_W'(in_col_reg) == eff_cols - CFG_COLS_W'(1));
    end

    // Register writes; any write restarts the matrix.
    always_comb
    begin
        cfg_rows_next = cfg_rows_reg;
        cfg_cols_next = cfg_cols_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        bank_next     = bank_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_MATRIX_ROWS)
            begin
                cfg_rows_next = cfg_wdata[ROW_W-1:0];
            end
            else if (cfg_index == REG_MATRIX_COLS)
            begin
                cfg_cols_next = cfg_wdata[CFG_COLS_W-1:0];
            end
            in_row_next = '0;
            in_col_next = '0;
            bank_next   = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                in_col_next = '0;
                if (last_row)
                begin
                    in_row_next = '0;
                    bank_next   = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_W'(1);
                    bank_next   = (bank_reg == BANK_W'(BANKS - 1)) ? '0
                                                                   : bank_reg + BANK_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rows_reg <= ROW_W'(RESET_ROWS);
            cfg_cols_reg <= CFG_COLS_W'(RESET_COLS);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            bank_reg     <= '0;
        end
        else
        begin
            cfg_rows_reg <= cfg_rows_next;
            cfg_cols_reg <= cfg_cols_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            bank_reg     <= bank_next;
        end
    end

    // Store addresses: the sample goes to its own row bank; port A fetches the
    // next element of the previous row, or column zero of this row at a row end;
    // port B fetches the element two rows up.
    always_comb
    begin
        bank_up1  = bank_prev(bank_reg);
        bank_up2  = bank_prev(bank_up1);
        wr_addr   = store_addr(bank_reg, in_col_reg);
        rd_addr_a = last_col ? store_addr(bank_reg, '0)
                             : store_addr(bank_up1, in_col_reg + COL_W'(1));
        rd_addr_b = store_addr(bank_up2, in_col_reg);
    end

    // Position flags travel with the sample.
    always_comb
    begin
        item_in.sample          = samples.sample_value;
        item_in.row             = in_row_reg;
        item_in.col             = in_col_reg;
        item_in.first_row       = (in_row_reg == '0);
        item_in.above_two       = (in_row_reg > ROW_W'(1));
        item_in.last_row        = last_row;
        item_in.first_col       = (in_col_reg == '0);
        item_in.past_second_col = (in_col_reg > COL_W'(1));
        item_in.last_col        = last_col;
    end

    fnms_line_store u_store (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (wr_addr),
        .wr_data   (samples.sample_value),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    fnms_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .item_in   (item_in),
        .rd_right  (rd_data_a),
        .rd_up     (rd_data_b),
        .take_ok   (take_ok),
        .grp_valid (grp_valid),
        .grp       (grp),
        .grp_ready (grp_ready)
    );

    fnms_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp       (grp),
        .grp_ready (grp_ready),
        .results   (results)
    );

    // The input position always lies inside the configured matrix.
    a_position_in_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        (CFG_COLS_W'(in_col_reg) < eff_cols) && (in_row_reg < eff_rows))
        else $error("input position outside the matrix");

endmodule

[hw/rtl/fnms_line_store.sv]
// ============================================================================
// fnms_line_store: three-row sample memory
// One write port and two read ports; read data is registered, so it is
// valid in the cycle after the read is issued.
// ============================================================================

module fnms_line_store import fnms_pkg::*; (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr_a,
    input  logic [ADDR_W-1:0]          rd_addr_b,
    output logic signed [SAMPLE_W-1:0] rd_data_a,
    output logic signed [SAMPLE_W-1:0] rd_data_b
);

    logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_a_reg;
    logic signed [SAMPLE_W-1:0] rd_data_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports, updated only when a read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[hw/rtl/fnms_gather.sv]
// ============================================================================
// fnms_gather: neighbour window and sum formation
// Holds the sample whose memory reads are in flight, keeps a short window
// of the previous row and of the current row, and forms the neighbour sums
// of every result that the sample completes.
// ============================================================================

module fnms_gather import fnms_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  item_t                      item_in,
    input  logic signed [SAMPLE_W-1:0] rd_right,
    input  logic signed [SAMPLE_W-1:0] rd_up,
    output logic                       take_ok,
    output logic                       grp_valid,
    output group_t                     grp,
    input  logic                       grp_ready
);

    logic                       valid_reg;
    item_t                      item_reg;
    logic signed [SAMPLE_W-1:0] up_left_reg;
    logic signed [SAMPLE_W-1:0] up_mid_reg;
    logic signed [SAMPLE_W-1:0] left1_reg;
    logic signed [SAMPLE_W-1:0] left2_reg;
    logic                       advance;
    logic [1:0]                 extra1;
    logic signed [SUM_W-1:0]    sum1;
    logic signed [SUM_W-1:0]    sum2;
    logic signed [SUM_W-1:0]    sum3;
    divisor_t                   div1;

    assign advance   = valid_reg && grp_ready;
    assign take_ok   = !valid_reg || grp_ready;
    assign grp_valid = valid_reg;

    // Occupancy of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    // Slide the window as the sample leaves. At the end of a row the
    // right-hand read returns column zero of this row for the next row.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            up_left_reg <= up_mid_reg;
            up_mid_reg  <= rd_right;
            left2_reg   <= left1_reg;
            left1_reg   <= item_reg.sample;
        end
    end

    // Element above, this sample below, neighbours left and right in the previous row.
    always_comb
    begin
        extra1 = {1'b0, item_reg.above_two} + {1'b0, !item_reg.first_col}
               + {1'b0, !item_reg.last_col};
        sum1 = (item_reg.above_two ? SUM_W'(rd_up) : '0)
             + SUM_W'(item_reg.sample)
             + (!item_reg.first_col ? SUM_W'(up_left_reg) : '0)
             + (!item_reg.last_col ? SUM_W'(rd_right) : '0);
        unique case (extra1)
            2'd1:    div1 = DIV_BY_2;
            2'd2:    div1 = DIV_BY_3;
            default: div1 = DIV_BY_4;
        endcase
    end

    // Bottom row: the element left of this sample, and the corner itself.
    always_comb
    begin
        sum2 = SUM_W'(up_left_reg) + SUM_W'(item_reg.sample)
             + (item_reg.past_second_col ? SUM_W'(left2_reg) : '0);
        sum3 = SUM_W'(up_mid_reg) + SUM_W'(left1_reg);
    end

    // Results in output order.
    always_comb
    begin
        grp.present[0]     = !item_reg.first_row;
        grp.present[1]     = item_reg.last_row && !item_reg.first_col;
        grp.present[2]     = item_reg.last_row && item_reg.last_col;

        grp.res[0].sum     = sum1;
        grp.res[0].divisor = div1;
        grp.res[0].row     = item_reg.row - ROW_W'(1);
        grp.res[0].col     = item_reg.col;
        grp.res[0].eom     = 1'b0;

        grp.res[1].sum     = sum2;
        grp.res[1].divisor = item_reg.past_second_col ? DIV_BY_3 : DIV_BY_2;
        grp.res[1].row     = item_reg.row;
        grp.res[1].col     = item_reg.col - COL_W'(1);
        grp.res[1].eom     = 1'b0;

        grp.res[2].sum     = sum3;
        grp.res[2].divisor = DIV_BY_2;
        grp.res[2].row     = item_reg.row;
        grp.res[2].col     = item_reg.col;
        grp.res[2].eom     = 1'b1;
    end

    // Results of one sample always come as a prefix of the group.
    a_present_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (grp.present == 3'b000 || grp.present == 3'b001
                    || grp.present == 3'b011 || grp.present == 3'b111))
        else $error("result group is not a prefix");

endmodule

[hw/rtl/fnms_emit.sv]
// ============================================================================
// fnms_emit: result queue, divider and output register
// Takes a group of up to three sums, hands them out one per cycle while the output
// is not stalled, divides each by its neighbour count with truncation toward zero
// and registers the result word.
// ============================================================================

module fnms_emit import fnms_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        grp_valid,
    input  group_t      grp,
    output logic        grp_ready,
    fnms_out_if.source  results
);

    result_t                    ent_reg [GROUP_MAX];
    logic [GROUP_IDX_W-1:0]     head_reg;
    logic [GROUP_IDX_W-1:0]     head_next;
    logic [REM_W-1:0]           rem_reg;
    logic [REM_W-1:0]           rem_next;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic                       out_last_reg;
    logic                       out_eom_reg;
    logic                       pop;
    logic                       load;
    logic [REM_W-1:0]           count;
    result_t                    cur;
    logic                       neg;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W-1:0]           quot;
    logic [MAG_W-1:0]           signed_q;
    logic [PROD_W-1:0]          prod;

    // Queue handshake: a new group enters as the last one leaves.
    assign pop       = (rem_reg != '0) && (!out_valid_reg || results.ready);
    assign grp_ready = (rem_reg == '0) || ((rem_reg == REM_W'(1)) && pop);
    assign load      = grp_valid && grp_ready;
    assign count     = REM_W'($countones(grp.present));

    always_comb
    begin
        head_next = head_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            head_next = '0;
            rem_next  = count;
        end
        else if (pop)
        begin
            head_next = head_reg + GROUP_IDX_W'(1);
            rem_next  = rem_reg - REM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < GROUP_MAX; i++)
            begin
                ent_reg[i] <= grp.res[i];
            end
        end
    end

    // Divide the magnitude by two, three or four, then restore the sign.
    always_comb
    begin
        cur  = ent_reg[head_reg];
        neg  = cur.sum[SUM_W-1];
        mag  = neg ? MAG_W'(-cur.sum) : MAG_W'(cur.sum);
        prod = PROD_W'(mag) * PROD_W'(RECIP3);
        unique case (cur.divisor)
            DIV_BY_2: quot = mag >> 1;
            DIV_BY_3: quot = MAG_W'(prod >> RECIP_SHIFT);
            DIV_BY_4: quot = mag >> 2;
            default:  quot = '0;
        endcase
        signed_q = neg ? (MAG_W'(0) - quot) : quot;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_value_reg <= signed_q[SAMPLE_W-1:0];
            out_row_reg   <= cur.row;
            out_col_reg   <= cur.col;
            out_last_reg  <= (rem_reg == REM_W'(1));
            out_eom_reg   <= cur.eom;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.smoothed_value = out_value_reg;
    assign results.out_row        = out_row_reg;
    assign results.out_col        = out_col_reg;
    assign results.last_in_run    = out_last_reg;
    assign results.end_of_matrix  = out_eom_reg;

    // The read pointer never runs past the loaded group.
    a_head_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> ({1'b0, head_reg} + {1'b0, rem_reg} <= 3'(GROUP_MAX)))
        else $error("queue head runs past the group");

    // The bottom-right result is always the last one of its sample.
    a_eom_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eom_reg) |-> out_last_reg)
        else $error("end of matrix without last in run");

endmodule
